// ===== sv/dssm_pkg.sv =====
// Shared types and constants for the dual stack shared memory unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package dssm_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int MAX_RESULTS   = 32;

  localparam logic [2:0] MODE_PUSH1  = 3'd0;
  localparam logic [2:0] MODE_PUSH2  = 3'd1;
  localparam logic [2:0] MODE_POP1   = 3'd2;
  localparam logic [2:0] MODE_POP2   = 3'd3;
  localparam logic [2:0] MODE_SHOW1  = 3'd4;
  localparam logic [2:0] MODE_SHOW2  = 3'd5;
  localparam logic [2:0] MODE_CLEAR1 = 3'd6;
  localparam logic [2:0] MODE_CLEAR2 = 3'd7;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;
  } rsp_word_t;

  typedef struct packed {
    logic start;
    logic step;
  } dssm_cmd_t;

  typedef struct packed {
    logic out_free;
    logic starts_walk;
    logic walk_last;
  } dssm_stat_t;

endpackage

`default_nettype wire

// ===== sv/dssm_ctrl.sv =====
// Controller: sequences word acceptance and memory walks (pop, show).
// Depends on dssm_pkg.
`default_nettype none

module dssm_ctrl
  import dssm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire dssm_stat_t stat,
  output dssm_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = stat.out_free;
        cmd.start = req_valid && stat.out_free;
        if (cmd.start && stat.starts_walk) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = stat.out_free;
        if (cmd.step && stat.walk_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dssm_datapath.sv =====
// Datapath: word memory, stack counts, walk address/length and output register.
// Depends on dssm_pkg.
`default_nettype none

module dssm_datapath
  import dssm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_word_t req,
  input  wire dssm_cmd_t cmd,
  output dssm_stat_t     stat,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_word_t      rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  logic [CW-1:0] low_count, high_count;
  logic [AW-1:0] walk_addr;
  logic [CW-1:0] walk_rem;
  logic          walk_down;

  logic          full, low_empty, high_empty;
  logic          is_push1, is_push2, is_pop1, is_pop2, is_show1, is_show2;
  logic          starts_walk;
  logic [1:0]    imm_status;
  logic [AW-1:0] start_addr, walk_addr_next, rd_addr, wr_addr;
  logic [CW-1:0] start_rem, show_count;
  logic          rd_en, wr_en, walk_last;

  assign full       = ({1'b0, low_count} + {1'b0, high_count}) >= (CW + 1)'(DEPTH);
  assign low_empty  = (low_count == '0);
  assign high_empty = (high_count == '0);

  assign is_push1 = (req.mode == MODE_PUSH1);
  assign is_push2 = (req.mode == MODE_PUSH2);
  assign is_pop1  = (req.mode == MODE_POP1);
  assign is_pop2  = (req.mode == MODE_POP2);
  assign is_show1 = (req.mode == MODE_SHOW1);
  assign is_show2 = (req.mode == MODE_SHOW2);

  assign starts_walk = ((is_pop1 || is_show1) && !low_empty) ||
                       ((is_pop2 || is_show2) && !high_empty);

  always_comb begin
    imm_status = STATUS_OK;
    if ((is_push1 || is_push2) && full) begin
      imm_status = STATUS_OVERFLOW;
    end else if ((is_pop1 || is_pop2 || is_show1 || is_show2) && !starts_walk) begin
      imm_status = STATUS_UNDERFLOW;
    end
  end

  assign show_count = is_show1 ? low_count : high_count;

  always_comb begin
    start_addr = '0;
    start_rem  = CW'(1);
    if (is_pop1) begin
      start_addr = AW'(low_count - CW'(1));
    end else if (is_pop2) begin
      start_addr = AW'(CW'(DEPTH) - high_count);
    end else begin
      start_addr = is_show1 ? '0 : AW'(DEPTH - 1);
      if ({{(32 - CW){1'b0}}, show_count} > 32'(MAX_RESULTS)) begin
        start_rem = CW'(MAX_RESULTS);
      end else begin
        start_rem = show_count;
      end
    end
  end

  assign walk_last      = (walk_rem == CW'(1));
  assign walk_addr_next = walk_down ? (walk_addr - AW'(1)) : (walk_addr + AW'(1));

  assign rd_en   = (cmd.start && starts_walk) || (cmd.step && !walk_last);
  assign rd_addr = cmd.start ? start_addr : walk_addr_next;

  assign wr_en   = cmd.start && (is_push1 || is_push2) && !full;
  assign wr_addr = is_push1 ? AW'(low_count) : AW'(CW'(DEPTH - 1) - high_count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // stack counts
  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
    end else if (cmd.start) begin
      case (req.mode)
        MODE_PUSH1:  if (!full) low_count <= low_count + CW'(1);
        MODE_PUSH2:  if (!full) high_count <= high_count + CW'(1);
        MODE_POP1:   if (!low_empty) low_count <= low_count - CW'(1);
        MODE_POP2:   if (!high_empty) high_count <= high_count - CW'(1);
        MODE_CLEAR1: low_count <= '0;
        MODE_CLEAR2: high_count <= '0;
        default: begin
        end
      endcase
    end
  end

  // walk position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      walk_addr <= start_addr;
      walk_rem  <= start_rem;
      walk_down <= is_show2;
    end else if (cmd.step) begin
      walk_addr <= walk_addr_next;
      walk_rem  <= walk_rem - CW'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((cmd.start && !starts_walk) || cmd.step) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rsp.status <= STATUS_OK;
      rsp.data   <= rd_data;
      rsp.last   <= walk_last;
    end else if (cmd.start && !starts_walk) begin
      rsp.status <= imm_status;
      rsp.data   <= '0;
      rsp.last   <= 1'b1;
    end
  end

  assign stat.out_free    = !rsp_valid || rsp_ready;
  assign stat.starts_walk = starts_walk;
  assign stat.walk_last   = walk_last;

endmodule

`default_nettype wire

// ===== sv/dual_stack_shared_memory_unit.sv =====
// Two stacks sharing one word memory of DEPTH entries.
// Channels: req (mode, value) in, rsp (status, data, last) out, valid/ready on each.
// Stack one grows up from entry 0, stack two down from entry DEPTH-1.
// Push and clear: one rsp word, registered in the cycle after acceptance.
// Pop: one rsp word via a registered memory read, then the output register.
// Show: streams min(count, 32) words base to top, one per cycle while rsp is
// taken; last marks the final word. Empty pop/show returns one underflow
// word; push into a full memory returns overflow.
// Throughput: push/clear/error one req per cycle while rsp is taken; no new
// req is taken until a pop or show walk ends (single memory read port, walk counter).
// A new req is taken while the previous rsp is being taken (output register).
// Receiver stall: rsp holds; the walk and req acceptance pause until it moves.
// Reset: both stacks empty, rsp_valid low; memory contents are not cleared
// and are only read where written.
// Depends on dssm_pkg, dssm_ctrl, dssm_datapath.
`default_nettype none

module dual_stack_shared_memory_unit
  import dssm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_word_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_word_t      rsp
);

  dssm_cmd_t  cmd;
  dssm_stat_t stat;

  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dssm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_walk_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && stat.starts_walk) |=> !req_ready)
    else $error("req accepted during walk");

  a_no_rsp_overwrite: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
    else $error("rsp word overwritten");

  a_error_word_shape: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != STATUS_OK) |-> (rsp.last && rsp.data == '0))
    else $error("bad error word");

endmodule

`default_nettype wire
